### design/saq_pkg.sv
// shortest-arc quaternion unit: shared widths, path codes and pipeline step functions
// used by saq_unit and shortest_arc_quaternion_unit; no dependencies
package saq_pkg;

  localparam int IN_W = 16;            // input component width
  localparam int FRAC = 14;            // output fraction bits
  localparam int OUT_W = 16;           // output component width
  localparam int VEC_W = IN_W + 1;     // room for a negated component
  localparam int MAG_W = IN_W;         // magnitude of a component
  localparam int NORM_W = 32;          // normalized magnitude, top bit at 30
  localparam int NORM_MSB = 30;
  localparam int UNIT_W = 32;          // signed q30 unit component
  localparam int SQ_W = 64;            // radicand width
  localparam int ROOT_W = 32;          // root width
  localparam int SQRT_STEPS = 32;
  localparam int REM_W = 63;           // divider remainder
  localparam int DEN_W = 48;           // divider divisor
  localparam int UDIV_STEPS = 31;      // quotient bits of the unit divide
  localparam int QDIV_STEPS = 28;      // quotient bits of the output divide
  localparam int OUT_SH = 30 - FRAC;

  // stage counts: unit = abs, normalize, square, sum, root, numerator, divide, sign
  localparam int UNIT_LAT = 4 + SQRT_STEPS + 1 + UDIV_STEPS + 1;
  // top = unit, product, cross/dot, classify, root, numerator, divide, final
  localparam int LAT = UNIT_LAT + 3 + SQRT_STEPS + 1 + QDIV_STEPS + 1;

  localparam logic [1:0] PATH_IDENT = 2'd0;
  localparam logic [1:0] PATH_GEN   = 2'd1;
  localparam logic [1:0] PATH_OPP   = 2'd2;
  localparam logic [1:0] PATH_DEGEN = 2'd3;

  typedef struct packed {
    logic [SQ_W-1:0] n;
    logic [SQ_W-1:0] r;
  } sqrt_st_t;

  typedef struct packed {
    logic [REM_W-1:0] rem;
    logic             hit;
  } div_st_t;

  // one iteration of the bitwise integer square root, bit weight 4^(31-k)
  function automatic sqrt_st_t sqrt_step(sqrt_st_t s, int k);
    logic [SQ_W-1:0] b;
    logic [SQ_W-1:0] t;
    sqrt_st_t o;
    b = SQ_W'(64'd1) << (62 - 2 * k);
    t = s.r + b;
    if (s.n >= t) begin
      o.n = s.n - t;
      o.r = (s.r >> 1) + b;
    end else begin
      o.n = s.n;
      o.r = s.r >> 1;
    end
    return o;
  endfunction

  // one restoring division step for quotient bit k
  function automatic div_st_t div_step(logic [REM_W-1:0] rem, logic [DEN_W-1:0] den, int k);
    div_st_t o;
    if ((rem >> k) >= REM_W'(den)) begin
      o.rem = rem - (REM_W'(den) << k);
      o.hit = 1'b1;
    end else begin
      o.rem = rem;
      o.hit = 1'b0;
    end
    return o;
  endfunction

endpackage

### design/saq_unit.sv
// saq_unit: pipelined scaling of a three-component vector to unit length in q30
// depends on saq_pkg (widths, sqrt_step, div_step)
module saq_unit import saq_pkg::*; (
  input  logic                     clk,
  input  logic                     en,
  input  logic signed [VEC_W-1:0]  vec [3],
  output logic signed [UNIT_W-1:0] uvec [3],
  output logic                     nz
);

  // stage 1: magnitudes
  logic [MAG_W-1:0]  s1_mag [3];
  logic              s1_neg [3];
  // stage 2: normalized magnitudes
  logic [NORM_W-1:0] s2_m [3];
  logic              s2_neg [3];
  logic              s2_nz;
  // stage 3: squares
  logic [SQ_W-1:0]   s3_sq [3];
  logic [NORM_W-1:0] s3_m [3];
  logic              s3_neg [3];
  logic              s3_nz;
  // stage 4: sum of squares
  logic [SQ_W-1:0]   s4_n2;
  logic [NORM_W-1:0] s4_m [3];
  logic              s4_neg [3];
  logic              s4_nz;
  // root stages
  sqrt_st_t          r_st [SQRT_STEPS];
  logic [NORM_W-1:0] r_m [SQRT_STEPS][3];
  logic              r_neg [SQRT_STEPS][3];
  logic              r_nz [SQRT_STEPS];
  // numerator stage
  logic [REM_W-1:0]  n_rem [3];
  logic [DEN_W-1:0]  n_den;
  logic              n_neg [3];
  logic              n_nz;
  // divide stages
  logic [REM_W-1:0]      d_rem [UDIV_STEPS][3];
  logic [UDIV_STEPS-1:0] d_q [UDIV_STEPS][3];
  logic [DEN_W-1:0]      d_den [UDIV_STEPS];
  logic                  d_neg [UDIV_STEPS][3];
  logic                  d_nz [UDIV_STEPS];

  logic [MAG_W-1:0]         mag [3];
  logic [MAG_W-1:0]         mx;
  logic [$clog2(MAG_W)-1:0] msb;
  logic [4:0]               shamt;
  logic [ROOT_W-1:0]        len;
  div_st_t                  dstep [UDIV_STEPS][3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mag[i] = vec[i][VEC_W-1] ? MAG_W'(-vec[i]) : MAG_W'(vec[i]);
    end
  end

  // leading one of the largest magnitude sets the normalizing shift
  always_comb begin
    mx = s1_mag[0];
    if (s1_mag[1] > mx) mx = s1_mag[1];
    if (s1_mag[2] > mx) mx = s1_mag[2];
    msb = '0;
    for (int j = 0; j < MAG_W; j++) begin
      if (mx[j]) msb = ($clog2(MAG_W))'(j);
    end
    shamt = 5'(NORM_MSB) - 5'(msb);
  end

  assign len = r_st[SQRT_STEPS-1].r[ROOT_W-1:0];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dstep[0][i] = div_step(n_rem[i], n_den, UDIV_STEPS - 1);
      for (int k = 1; k < UDIV_STEPS; k++) begin
        dstep[k][i] = div_step(d_rem[k-1][i], d_den[k-1], UDIV_STEPS - 1 - k);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        s1_mag[i] <= mag[i];
        s1_neg[i] <= vec[i][VEC_W-1];
        s2_m[i]   <= NORM_W'(s1_mag[i]) << shamt;
        s2_neg[i] <= s1_neg[i];
        s3_sq[i]  <= SQ_W'(s2_m[i]) * SQ_W'(s2_m[i]);
        s3_m[i]   <= s2_m[i];
        s3_neg[i] <= s2_neg[i];
        s4_m[i]   <= s3_m[i];
        s4_neg[i] <= s3_neg[i];
      end
      s2_nz <= (mx != '0);
      s3_nz <= s2_nz;
      s4_n2 <= s3_sq[0] + s3_sq[1] + s3_sq[2];
      s4_nz <= s3_nz;

      r_st[0] <= sqrt_step(sqrt_st_t'({s4_n2, {SQ_W{1'b0}}}), 0);
      r_nz[0] <= s4_nz;
      for (int i = 0; i < 3; i++) begin
        r_m[0][i]   <= s4_m[i];
        r_neg[0][i] <= s4_neg[i];
      end
      for (int k = 1; k < SQRT_STEPS; k++) begin
        r_st[k] <= sqrt_step(r_st[k-1], k);
        r_nz[k] <= r_nz[k-1];
        for (int i = 0; i < 3; i++) begin
          r_m[k][i]   <= r_m[k-1][i];
          r_neg[k][i] <= r_neg[k-1][i];
        end
      end

      // numerator is m * 2^30 plus half the length, for rounding
      for (int i = 0; i < 3; i++) begin
        n_rem[i] <= REM_W'({r_m[SQRT_STEPS-1][i], 30'd0}) + REM_W'(len >> 1);
        n_neg[i] <= r_neg[SQRT_STEPS-1][i];
      end
      n_den <= DEN_W'(len);
      n_nz  <= r_nz[SQRT_STEPS-1];

      for (int i = 0; i < 3; i++) begin
        d_rem[0][i] <= dstep[0][i].rem;
        d_q[0][i]   <= UDIV_STEPS'(dstep[0][i].hit);
        d_neg[0][i] <= n_neg[i];
      end
      d_den[0] <= n_den;
      d_nz[0]  <= n_nz;
      for (int k = 1; k < UDIV_STEPS; k++) begin
        for (int i = 0; i < 3; i++) begin
          d_rem[k][i] <= dstep[k][i].rem;
          d_q[k][i]   <= {d_q[k-1][i][UDIV_STEPS-2:0], dstep[k][i].hit};
          d_neg[k][i] <= d_neg[k-1][i];
        end
        d_den[k] <= d_den[k-1];
        d_nz[k]  <= d_nz[k-1];
      end

      for (int i = 0; i < 3; i++) begin
        uvec[i] <= d_neg[UDIV_STEPS-1][i] ? -UNIT_W'(d_q[UDIV_STEPS-1][i])
                                          : UNIT_W'(d_q[UDIV_STEPS-1][i]);
      end
      nz <= d_nz[UDIV_STEPS-1];
    end
  end

endmodule

### design/shortest_arc_quaternion_unit.sv
// shortest_arc_quaternion_unit: top level of the shortest-arc rotation quaternion pipeline
// depends on saq_pkg and three saq_unit instances (source, destination, half-turn axis)
//
// usage
//   input channel: in_valid/in_ready with src, dst and fallback axis components; an item
//   is taken on a clock edge where both are high. output channel: out_valid/out_ready
//   with quat_x/y/z/w in q1.14 and a path code (identity, general, half turn, degenerate).
//   items are independent, one result per item, in order.
// timing
//   fully pipelined: one item per cycle sustained while the output is not stalled. the
//   pipeline depth is set by the two 32-step square roots and the 31- and 28-step
//   restoring dividers, one step per stage.
// stall
//   the pipeline runs while the one-entry skid buffer is empty; a stalled receiver keeps
//   the item in the output register, the next finished item drops into the skid buffer,
//   and then in_ready falls and the whole pipeline holds until the output drains.
// reset
//   rst (synchronous) clears the valid bits, the output and skid flags; in_ready is high
//   in the cycle after reset. there is no configuration and no stored state per item.
module shortest_arc_quaternion_unit import saq_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic signed [IN_W-1:0]  src_x,
  input  logic signed [IN_W-1:0]  src_y,
  input  logic signed [IN_W-1:0]  src_z,
  input  logic signed [IN_W-1:0]  dst_x,
  input  logic signed [IN_W-1:0]  dst_y,
  input  logic signed [IN_W-1:0]  dst_z,
  input  logic signed [IN_W-1:0]  fall_x,
  input  logic signed [IN_W-1:0]  fall_y,
  input  logic signed [IN_W-1:0]  fall_z,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic signed [OUT_W-1:0] quat_x,
  output logic signed [OUT_W-1:0] quat_y,
  output logic signed [OUT_W-1:0] quat_z,
  output logic signed [OUT_W-1:0] quat_w,
  output logic [1:0]              path
);

  localparam logic signed [63:0] ONE_Q60 = 64'sd1 <<< 60;
  localparam logic signed [63:0] EPS_Q60 = 64'sd1 <<< 34;  // nearly-opposite bound on 1+d
  localparam logic [OUT_W-1:0]   ONE_OUT = OUT_W'(1 << FRAC);

  // clamp a magnitude to one and apply the sign
  function automatic logic [OUT_W-1:0] enc(logic [QDIV_STEPS-1:0] m, logic neg);
    logic [OUT_W-1:0] c;
    c = (m > QDIV_STEPS'(ONE_OUT)) ? ONE_OUT : m[OUT_W-1:0];
    return neg ? OUT_W'(-c) : c;
  endfunction

  logic en;
  logic vld [LAT];

  // input vectors and fallback axis choice
  logic signed [VEC_W-1:0]  vsrc [3];
  logic signed [VEC_W-1:0]  vdst [3];
  logic signed [VEC_W-1:0]  vax [3];
  logic signed [UNIT_W-1:0] us [3];
  logic signed [UNIT_W-1:0] ud [3];
  logic signed [UNIT_W-1:0] ua [3];
  logic                     nzs;
  logic                     nzd;

  always_comb begin
    vsrc[0] = VEC_W'(src_x);
    vsrc[1] = VEC_W'(src_y);
    vsrc[2] = VEC_W'(src_z);
    vdst[0] = VEC_W'(dst_x);
    vdst[1] = VEC_W'(dst_y);
    vdst[2] = VEC_W'(dst_z);
    if (fall_x != '0 || fall_y != '0 || fall_z != '0) begin
      vax[0] = VEC_W'(fall_x);
      vax[1] = VEC_W'(fall_y);
      vax[2] = VEC_W'(fall_z);
    end else if (src_y != '0 || src_z != '0) begin
      // unit x cross source
      vax[0] = '0;
      vax[1] = -vsrc[2];
      vax[2] = vsrc[1];
    end else begin
      // unit y cross source
      vax[0] = vsrc[2];
      vax[1] = '0;
      vax[2] = -vsrc[0];
    end
  end

  saq_unit u_src (.clk(clk), .en(en), .vec(vsrc), .uvec(us), .nz(nzs));
  saq_unit u_dst (.clk(clk), .en(en), .vec(vdst), .uvec(ud), .nz(nzd));
  saq_unit u_ax  (.clk(clk), .en(en), .vec(vax),  .uvec(ua), .nz());

  // product stage
  logic signed [63:0]       t1_pr [3][3];
  logic                     t1_ok;
  logic signed [UNIT_W-1:0] t1_ax [3];
  // cross and dot stage
  logic signed [63:0]       t2_c [3];
  logic signed [63:0]       t2_dot;
  logic                     t2_ok;
  logic signed [UNIT_W-1:0] t2_ax [3];
  // classify stage
  logic [SQ_W-1:0]          t3_val;
  logic [REM_W-1:0]         t3_cm [3];
  logic                     t3_cneg [3];
  logic [1:0]               t3_path;
  logic [OUT_W-1:0]         t3_axq [3];
  // root stages
  sqrt_st_t                 r_st [SQRT_STEPS];
  logic [REM_W-1:0]         r_cm [SQRT_STEPS][3];
  logic                     r_cneg [SQRT_STEPS][3];
  logic [1:0]               r_path [SQRT_STEPS];
  logic [OUT_W-1:0]         r_axq [SQRT_STEPS][3];
  // numerator stage
  logic [REM_W-1:0]         n_rem [3];
  logic [DEN_W-1:0]         n_den;
  logic                     n_cneg [3];
  logic [1:0]               n_path;
  logic [OUT_W-1:0]         n_axq [3];
  logic [OUT_W-1:0]         n_wq;
  // divide stages
  logic [REM_W-1:0]         d_rem [QDIV_STEPS][3];
  logic [QDIV_STEPS-1:0]    d_q [QDIV_STEPS][3];
  logic [DEN_W-1:0]         d_den [QDIV_STEPS];
  logic                     d_cneg [QDIV_STEPS][3];
  logic [1:0]               d_path [QDIV_STEPS];
  logic [OUT_W-1:0]         d_axq [QDIV_STEPS][3];
  logic [OUT_W-1:0]         d_wq [QDIV_STEPS];
  // last pipeline stage
  logic [OUT_W-1:0]         p_q [4];
  logic [1:0]               p_path;
  // output register and skid buffer
  logic [OUT_W-1:0]         o_q [4];
  logic [1:0]               o_path;
  logic [OUT_W-1:0]         k_q [4];
  logic [1:0]               k_path;
  logic                     skid_valid;

  // combinational values of the classify, numerator, divide and final stages
  logic signed [63:0]  onepd;
  logic [UNIT_W-1:0]   axm [3];
  logic [UNIT_W:0]     axr [3];
  logic [ROOT_W-1:0]   root;
  logic [DEN_W-1:0]    den;
  logic [ROOT_W:0]     wsum;
  div_st_t             dstep [QDIV_STEPS][3];
  logic [OUT_W-1:0]    fin_q [4];

  always_comb begin
    onepd = ONE_Q60 + t2_dot;
    for (int i = 0; i < 3; i++) begin
      axm[i] = t2_ax[i][UNIT_W-1] ? UNIT_W'(-t2_ax[i]) : UNIT_W'(t2_ax[i]);
      axr[i] = ((UNIT_W+1)'(axm[i]) + ((UNIT_W+1)'(1) << (OUT_SH - 1))) >> OUT_SH;
    end
  end

  // root of 2(1+d) gives s in q30; divisor is s scaled to the output fraction
  always_comb begin
    root = r_st[SQRT_STEPS-1].r[ROOT_W-1:0];
    den  = DEN_W'(root) << OUT_SH;
    wsum = ((ROOT_W+1)'(root) + ((ROOT_W+1)'(1) << OUT_SH)) >> (OUT_SH + 1);
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dstep[0][i] = div_step(n_rem[i], n_den, QDIV_STEPS - 1);
      for (int k = 1; k < QDIV_STEPS; k++) begin
        dstep[k][i] = div_step(d_rem[k-1][i], d_den[k-1], QDIV_STEPS - 1 - k);
      end
    end
  end

  // final selection by path
  always_comb begin
    case (d_path[QDIV_STEPS-1])
      PATH_GEN: begin
        for (int i = 0; i < 3; i++) begin
          fin_q[i] = enc(d_q[QDIV_STEPS-1][i], d_cneg[QDIV_STEPS-1][i]);
        end
        fin_q[3] = d_wq[QDIV_STEPS-1];
      end
      PATH_OPP: begin
        for (int i = 0; i < 3; i++) begin
          fin_q[i] = d_axq[QDIV_STEPS-1][i];
        end
        fin_q[3] = '0;
      end
      default: begin
        // identity and degenerate input
        fin_q[0] = '0;
        fin_q[1] = '0;
        fin_q[2] = '0;
        fin_q[3] = ONE_OUT;
      end
    endcase
  end

  // pipeline advances while the skid buffer is free
  assign en       = !skid_valid;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < LAT; k++) vld[k] <= 1'b0;
    end else if (en) begin
      vld[0] <= in_valid;
      for (int k = 1; k < LAT; k++) vld[k] <= vld[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int a = 0; a < 3; a++) begin
        for (int b = 0; b < 3; b++) begin
          t1_pr[a][b] <= 64'(us[a]) * 64'(ud[b]);
        end
        t1_ax[a] <= ua[a];
        t2_ax[a] <= t1_ax[a];
      end
      t1_ok <= nzs & nzd;

      t2_c[0] <= t1_pr[1][2] - t1_pr[2][1];
      t2_c[1] <= t1_pr[2][0] - t1_pr[0][2];
      t2_c[2] <= t1_pr[0][1] - t1_pr[1][0];
      t2_dot  <= t1_pr[0][0] + t1_pr[1][1] + t1_pr[2][2];
      t2_ok   <= t1_ok;

      if (!t2_ok) begin
        t3_path <= PATH_DEGEN;
      end else if (t2_dot >= ONE_Q60) begin
        t3_path <= PATH_IDENT;
      end else if (onepd < EPS_Q60) begin
        t3_path <= PATH_OPP;
      end else begin
        t3_path <= PATH_GEN;
      end
      t3_val <= SQ_W'(onepd) << 1;
      for (int i = 0; i < 3; i++) begin
        t3_cm[i]   <= t2_c[i][63] ? REM_W'(-t2_c[i]) : REM_W'(t2_c[i]);
        t3_cneg[i] <= t2_c[i][63];
        t3_axq[i]  <= enc(QDIV_STEPS'(axr[i]), t2_ax[i][UNIT_W-1]);
      end

      r_st[0]   <= sqrt_step(sqrt_st_t'({t3_val, {SQ_W{1'b0}}}), 0);
      r_path[0] <= t3_path;
      for (int i = 0; i < 3; i++) begin
        r_cm[0][i]   <= t3_cm[i];
        r_cneg[0][i] <= t3_cneg[i];
        r_axq[0][i]  <= t3_axq[i];
      end
      for (int k = 1; k < SQRT_STEPS; k++) begin
        r_st[k]   <= sqrt_step(r_st[k-1], k);
        r_path[k] <= r_path[k-1];
        for (int i = 0; i < 3; i++) begin
          r_cm[k][i]   <= r_cm[k-1][i];
          r_cneg[k][i] <= r_cneg[k-1][i];
          r_axq[k][i]  <= r_axq[k-1][i];
        end
      end

      // cross over s, rounded half away from zero
      for (int i = 0; i < 3; i++) begin
        n_rem[i]  <= r_cm[SQRT_STEPS-1][i] + REM_W'(den >> 1);
        n_cneg[i] <= r_cneg[SQRT_STEPS-1][i];
        n_axq[i]  <= r_axq[SQRT_STEPS-1][i];
      end
      n_den  <= den;
      n_path <= r_path[SQRT_STEPS-1];
      n_wq   <= enc(QDIV_STEPS'(wsum), 1'b0);

      for (int i = 0; i < 3; i++) begin
        d_rem[0][i]  <= dstep[0][i].rem;
        d_q[0][i]    <= QDIV_STEPS'(dstep[0][i].hit);
        d_cneg[0][i] <= n_cneg[i];
        d_axq[0][i]  <= n_axq[i];
      end
      d_den[0]  <= n_den;
      d_path[0] <= n_path;
      d_wq[0]   <= n_wq;
      for (int k = 1; k < QDIV_STEPS; k++) begin
        for (int i = 0; i < 3; i++) begin
          d_rem[k][i]  <= dstep[k][i].rem;
          d_q[k][i]    <= {d_q[k-1][i][QDIV_STEPS-2:0], dstep[k][i].hit};
          d_cneg[k][i] <= d_cneg[k-1][i];
          d_axq[k][i]  <= d_axq[k-1][i];
        end
        d_den[k]  <= d_den[k-1];
        d_path[k] <= d_path[k-1];
        d_wq[k]   <= d_wq[k-1];
      end

      for (int i = 0; i < 4; i++) p_q[i] <= fin_q[i];
      p_path <= d_path[QDIV_STEPS-1];
    end
  end

  // output register with one-entry skid buffer behind it
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (out_ready) begin
        skid_valid <= 1'b0;
      end
    end else if (vld[LAT-1]) begin
      if (!out_valid || out_ready) begin
        out_valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (out_ready) begin
        for (int i = 0; i < 4; i++) o_q[i] <= k_q[i];
        o_path <= k_path;
      end
    end else if (vld[LAT-1]) begin
      if (!out_valid || out_ready) begin
        for (int i = 0; i < 4; i++) o_q[i] <= p_q[i];
        o_path <= p_path;
      end else begin
        for (int i = 0; i < 4; i++) k_q[i] <= p_q[i];
        k_path <= p_path;
      end
    end
  end

  assign quat_x = o_q[0];
  assign quat_y = o_q[1];
  assign quat_z = o_q[2];
  assign quat_w = o_q[3];
  assign path   = o_path;

endmodule
